### sv/bgc_pkg.sv
// bgc_pkg: shared types and constants for the button gesture classifier
// no dependencies; used by bgc_cfg, bgc_core and button_gesture_classifier
package bgc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned IdxW  = 2;

	localparam logic [CfgW-1:0] DebounceRst = 16'd50;
	localparam logic [CfgW-1:0] LongRst     = 16'd500;
	localparam logic [CfgW-1:0] DoubleRst   = 16'd300;

	typedef enum logic [IdxW-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_DOUBLE   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} ev_t;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] long_press_ms;
		logic [CfgW-1:0] double_press_ms;
	} cfg_t;

endpackage

### sv/bgc_cfg.sv
// bgc_cfg: configuration register file (debounce, long press, double press)
// depends on bgc_pkg
module bgc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [bgc_pkg::IdxW-1:0]    wr_index,
	input  logic [bgc_pkg::CfgW-1:0]    wr_data,
	output bgc_pkg::cfg_t               cfg
);

	bgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bgc_pkg::DebounceRst;
			cfg_q.long_press_ms   <= bgc_pkg::LongRst;
			cfg_q.double_press_ms <= bgc_pkg::DoubleRst;
		end else if (wr_en) begin
			unique case (wr_index)
				bgc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms     <= wr_data;
				bgc_pkg::REG_LONG:     cfg_q.long_press_ms   <= wr_data;
				bgc_pkg::REG_DOUBLE:   cfg_q.double_press_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/bgc_core.sv
// bgc_core: button state registers and the per-request classification logic
// depends on bgc_pkg
module bgc_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         op,
	input  logic [bgc_pkg::TimeW-1:0]    now_ms,
	input  bgc_pkg::cfg_t                cfg,
	output bgc_pkg::ev_t                 ev,
	output logic                         chg
);

	logic                       is_pressed_q, was_released_q, press_handled_q, awaiting_q;
	logic [bgc_pkg::TimeW-1:0]  last_edge_q, press_start_q, first_click_q;

	logic                       is_pressed_d, was_released_d, press_handled_d, awaiting_d;
	logic [bgc_pkg::TimeW-1:0]  last_edge_d, press_start_d, first_click_d;

	logic [bgc_pkg::TimeW-1:0]  since_edge, held, since_click_d;
	logic [bgc_pkg::TimeW-1:0]  long_ext, dbl_ext, deb_ext;
	logic                       is_long, in_window, returned;

	assign long_ext   = {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, cfg.long_press_ms};
	assign dbl_ext    = {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, cfg.double_press_ms};
	assign deb_ext    = {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, cfg.debounce_ms};
	assign since_edge = now_ms - last_edge_q;
	assign held       = now_ms - press_start_q;
	assign is_long    = held >= long_ext;
	assign in_window  = (now_ms - first_click_q) <= dbl_ext;

	always_comb begin
		is_pressed_d    = is_pressed_q;
		was_released_d  = was_released_q;
		press_handled_d = press_handled_q;
		awaiting_d      = awaiting_q;
		last_edge_d     = last_edge_q;
		press_start_d   = press_start_q;
		first_click_d   = first_click_q;
		ev              = bgc_pkg::EV_NONE;
		chg             = 1'b0;
		returned        = 1'b0;
		since_click_d   = '0;
		if (op == bgc_pkg::OP_EDGE) begin
			if (since_edge >= deb_ext) begin
				last_edge_d = now_ms;
				if (!is_pressed_q) begin
					press_start_d   = now_ms;
					is_pressed_d    = 1'b1;
					was_released_d  = 1'b0;
					press_handled_d = 1'b0;
				end else begin
					is_pressed_d   = 1'b0;
					was_released_d = 1'b1;
				end
			end
		end else begin
			if (!press_handled_q) begin
				if (is_pressed_q && is_long) begin
					ev              = bgc_pkg::EV_LONG;
					chg             = 1'b1;
					press_handled_d = 1'b1;
				end
				if (was_released_q) begin
					if (!is_long) begin
						if (awaiting_q && in_window) begin
							// double press skips the window-expiry check
							ev              = bgc_pkg::EV_DOUBLE;
							chg             = 1'b0;
							awaiting_d      = 1'b0;
							press_handled_d = 1'b1;
							returned        = 1'b1;
						end else if (!awaiting_q) begin
							awaiting_d      = 1'b1;
							first_click_d   = now_ms;
							press_handled_d = 1'b1;
						end
					end else begin
						ev              = bgc_pkg::EV_LONG;
						chg             = 1'b1;
						press_handled_d = 1'b1;
					end
				end
			end
			since_click_d = now_ms - first_click_d;
			if (!returned && awaiting_d && (since_click_d > dbl_ext)) begin
				ev              = bgc_pkg::EV_SHORT;
				chg             = 1'b1;
				press_handled_d = 1'b1;
				awaiting_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q    <= 1'b0;
			was_released_q  <= 1'b0;
			press_handled_q <= 1'b1;
			awaiting_q      <= 1'b0;
			last_edge_q     <= '0;
			press_start_q   <= '0;
			first_click_q   <= '0;
		end else if (advance) begin
			is_pressed_q    <= is_pressed_d;
			was_released_q  <= was_released_d;
			press_handled_q <= press_handled_d;
			awaiting_q      <= awaiting_d;
			last_edge_q     <= last_edge_d;
			press_start_q   <= press_start_d;
			first_click_q   <= first_click_d;
		end
	end

endmodule

### sv/button_gesture_classifier.sv
// button_gesture_classifier: top level, input register, result register
// depends on bgc_pkg, bgc_cfg and bgc_core
// a request is held in the input register, then its result in the result register, which drives the result port
// throughput: one request per cycle while out_ready does not stall the result register
// reset: button state to idle, registers to 50/500/300 ms, both pipeline stages empty
// config writes are taken every cycle (cfg_ready tied high)
module button_gesture_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [bgc_pkg::TimeW-1:0]    now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   event_code,
	output logic                         changed_flag,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bgc_pkg::IdxW-1:0]     cfg_index,
	input  logic [bgc_pkg::CfgW-1:0]     cfg_data
);

	logic                       valid_s1, op_s1;
	logic [bgc_pkg::TimeW-1:0]  now_s1;
	logic                       valid_s2, chg_s2;
	bgc_pkg::ev_t               ev_s2;
	logic                       advance, chg;
	bgc_pkg::ev_t               ev;
	bgc_pkg::cfg_t              cfg;

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	bgc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bgc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.now_ms  (now_s1),
		.cfg     (cfg),
		.ev      (ev),
		.chg     (chg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			now_s1 <= now_ms;
		end
		if (advance) begin
			ev_s2  <= ev;
			chg_s2 <= chg;
		end
	end

	assign out_valid    = valid_s2;
	assign event_code   = ev_s2;
	assign changed_flag = chg_s2;

endmodule

### dv/gesture_check_pkg.sv
// gesture_check_pkg: predictor and result checker for the button gesture classifier
// depends on bgc_pkg for the register indexes, event codes and reset values
package gesture_check_pkg;

	import bgc_pkg::*;

	typedef struct packed {
		ev_t  code;
		logic chg;
	} gesture_t;

	class gesture_model;
		logic [CfgW-1:0]  debounce_ms;
		logic [CfgW-1:0]  long_ms;
		logic [CfgW-1:0]  double_ms;
		bit               pressed;
		bit               released;
		bit               handled;
		bit               awaiting;
		logic [TimeW-1:0] last_edge;
		logic [TimeW-1:0] press_start;
		logic [TimeW-1:0] first_click;
		gesture_t         expected_q[$];
		int unsigned      mismatches;
		int unsigned      seen[4];

		function new();
			debounce_ms = DebounceRst;
			long_ms     = LongRst;
			double_ms   = DoubleRst;
			pressed     = 1'b0;
			released    = 1'b0;
			handled     = 1'b1;
			awaiting    = 1'b0;
			last_edge   = '0;
			press_start = '0;
			first_click = '0;
			mismatches  = 0;
			seen        = '{default: 0};
		endfunction

		function void set_reg(reg_idx_t idx, logic [CfgW-1:0] val);
			case (idx)
				REG_DEBOUNCE: debounce_ms = val;
				REG_LONG:     long_ms = val;
				REG_DOUBLE:   double_ms = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// all differences are taken modulo 2^32
		function logic [TimeW-1:0] elapsed(logic [TimeW-1:0] now, logic [TimeW-1:0] since);
			return now - since;
		endfunction

		function void note_request(op_t op, logic [TimeW-1:0] now);
			gesture_t         g;
			logic [TimeW-1:0] held;
			bit               paired;
			g.code = EV_NONE;
			g.chg  = 1'b0;
			paired = 1'b0;
			if (op == OP_EDGE) begin
				if (elapsed(now, last_edge) >= {16'd0, debounce_ms}) begin
					last_edge = now;
					if (!pressed) begin
						press_start = now;
						pressed     = 1'b1;
						released    = 1'b0;
						handled     = 1'b0;
					end else begin
						pressed  = 1'b0;
						released = 1'b1;
					end
				end
			end else begin
				held = elapsed(now, press_start);
				if (!handled) begin
					if (pressed && held >= {16'd0, long_ms}) begin
						g.code  = EV_LONG;
						g.chg   = 1'b1;
						handled = 1'b1;
					end
					if (released) begin
						if (held < {16'd0, long_ms}) begin
							if (awaiting && elapsed(now, first_click) <= {16'd0, double_ms}) begin
								// double press leaves changed_flag low and skips the window check
								g.code   = EV_DOUBLE;
								awaiting = 1'b0;
								handled  = 1'b1;
								paired   = 1'b1;
							end else if (!awaiting) begin
								awaiting    = 1'b1;
								first_click = now;
								handled     = 1'b1;
							end
						end else begin
							g.code  = EV_LONG;
							g.chg   = 1'b1;
							handled = 1'b1;
						end
					end
				end
				// an expired window wins over a long press in the same poll
				if (!paired && awaiting && elapsed(now, first_click) > {16'd0, double_ms}) begin
					g.code   = EV_SHORT;
					g.chg    = 1'b1;
					handled  = 1'b1;
					awaiting = 1'b0;
				end
			end
			expected_q.push_back(g);
		endfunction

		function void check_result(ev_t code, logic chg, time stamp);
			gesture_t g;
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with nothing outstanding, event_code %0d changed_flag %0b",
					stamp, code, chg);
				return;
			end
			g = expected_q.pop_front();
			seen[code]++;
			if (code !== g.code) begin
				mismatches++;
				$display("%0t ns: event_code expected %0d (%s) got %0d",
					stamp, g.code, g.code.name(), code);
			end
			if (chg !== g.chg) begin
				mismatches++;
				$display("%0t ns: changed_flag expected %0b got %0b", stamp, g.chg, chg);
			end
		endfunction
	endclass

endpackage

### dv/testbench.sv
// testbench: drives button_gesture_classifier with press, release and poll requests
// under several register settings and checks every result against gesture_check_pkg
// depends on bgc_pkg, gesture_check_pkg and the block's RTL
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import bgc_pkg::*;
	import gesture_check_pkg::*;

	localparam int unsigned PhaseItems = 205;
	localparam int unsigned CycleLimit = 500000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                op = OP_EDGE;
	logic [TimeW-1:0]    now_ms = '0;
	logic                out_ready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic [IdxW-1:0]     cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;
	logic                in_ready;
	logic                out_valid;
	logic [1:0]          event_code;
	logic                changed_flag;
	logic                cfg_ready;

	gesture_model        gestures = new();
	bit                  idling = 1'b1;
	int unsigned         requests = 0;
	int unsigned         settings_used = 1;
	int unsigned         cycles = 0;
	logic [TimeW-1:0]    wall_ms;
	logic [TimeW-1:0]    deb_ms = TimeW'(DebounceRst);
	logic [TimeW-1:0]    long_ms = TimeW'(LongRst);
	logic [TimeW-1:0]    dbl_ms = TimeW'(DoubleRst);

	button_gesture_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_code   (event_code),
		.changed_flag (changed_flag),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("button_gesture_classifier verification failed");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			gestures.check_result(ev_t'(event_code), changed_flag, $time);
	end

	// called at a clock edge; returns at the edge where the request is taken
	task automatic send(op_t o, logic [TimeW-1:0] t);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		now_ms   <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gestures.note_request(o, t);
		requests++;
	endtask

	task automatic apply_setting(logic [CfgW-1:0] d, logic [CfgW-1:0] l, logic [CfgW-1:0] w);
		logic [CfgW-1:0] vals[3];
		vals = '{d, l, w};
		in_valid <= 1'b0;
		while (gestures.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			gestures.set_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		deb_ms = TimeW'(d);
		long_ms = TimeW'(l);
		dbl_ms = TimeW'(w);
		settings_used++;
	endtask

	// a delay clustered around a threshold, with the odd tiny one
	function automatic logic [TimeW-1:0] around_ms(logic [TimeW-1:0] thr);
		case ($urandom_range(0, 5))
			0:       return (thr == 0) ? thr : thr - 1;
			1:       return thr;
			2:       return thr + 1;
			3:       return $urandom_range(0, thr);
			4:       return thr + $urandom_range(0, thr / 2 + 2);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	task automatic click(bit hold_long);
		logic [TimeW-1:0] hold;
		wall_ms += ($urandom_range(0, 7) == 0) ? around_ms(deb_ms) : deb_ms + $urandom_range(0, 30);
		send(OP_EDGE, wall_ms);
		if ($urandom_range(0, 4) == 0)
			send(OP_EDGE, wall_ms + around_ms(deb_ms));
		if (hold_long)
			hold = around_ms(long_ms);
		else if ($urandom_range(0, 3) == 0)
			hold = around_ms(deb_ms);
		else
			hold = deb_ms + $urandom_range(0, long_ms / 2);
		if (hold_long || $urandom_range(0, 3) == 0)
			send(OP_POLL, wall_ms + around_ms(long_ms));
		wall_ms += hold;
		send(OP_EDGE, wall_ms);
		wall_ms += $urandom_range(0, 5);
		send(OP_POLL, wall_ms);
	endtask

	task automatic gesture();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				// stray requests with arbitrary timestamps
				repeat ($urandom_range(1, 3)) send(op_t'($urandom_range(0, 1)), $urandom());
				if ($urandom_range(0, 1) == 0)
					wall_ms = $urandom();
			end
			1, 2, 3: begin
				click(1'b0);
				repeat ($urandom_range(1, 2)) begin
					wall_ms += around_ms(dbl_ms);
					send(OP_POLL, wall_ms);
				end
			end
			4, 5, 6: begin
				click(1'b0);
				click(1'b0);
				wall_ms += around_ms(dbl_ms);
				send(OP_POLL, wall_ms);
			end
			7, 8: begin
				click(1'b1);
				wall_ms += around_ms(dbl_ms);
				send(OP_POLL, wall_ms);
			end
			default: begin
				// second click close to the end of the window
				click(1'b0);
				wall_ms += around_ms(dbl_ms);
				click(1'b0);
				wall_ms += around_ms(dbl_ms);
				send(OP_POLL, wall_ms);
			end
		endcase
	endtask

	initial begin
		logic [TimeW:0] intro[$] = '{
			{OP_EDGE, 32'd0},          // bounce right after reset
			{OP_EDGE, 32'd100},
			{OP_POLL, 32'd599},        // one ms short of long
			{OP_EDGE, 32'd200},
			{OP_POLL, 32'd250},        // first click, window opens
			{OP_EDGE, 32'd300},
			{OP_EDGE, 32'd320},        // bounce
			{OP_EDGE, 32'd400},
			{OP_POLL, 32'd550},        // double at the window edge
			{OP_EDGE, 32'd1000},
			{OP_POLL, 32'd1500},       // long while held
			{OP_EDGE, 32'd1600},
			{OP_EDGE, 32'd2000},
			{OP_EDGE, 32'd2100},
			{OP_POLL, 32'd2110},
			{OP_POLL, 32'd2411},       // window expired: short
			{OP_EDGE, 32'd5000},
			{OP_EDGE, 32'd5100},
			{OP_POLL, 32'd5110},
			{OP_EDGE, 32'd5200},
			{OP_EDGE, 32'd5300},
			{OP_POLL, 32'd5500},       // late second click dropped
			{OP_EDGE, 32'd6000},
			{OP_EDGE, 32'd6100},
			{OP_POLL, 32'd6110},
			{OP_EDGE, 32'd6200},
			{OP_POLL, 32'd6800},       // long and expiry in one poll
			{OP_EDGE, 32'hFFFF_FFFF}
		};
		logic [CfgW-1:0] settings[6][3] = '{
			'{16'd0, 16'd0, 16'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{16'd1, 16'd1, 16'd1},
			'{16'd20, 16'd120, 16'd90},
			'{16'd0, 16'd0, 16'd0},
			'{DebounceRst, LongRst, DoubleRst}
		};
		int unsigned phase_end;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (intro[k])
			send(op_t'(intro[k][TimeW]), intro[k][TimeW-1:0]);

		for (int p = 0; p <= 6; p++) begin
			if (p > 0) begin
				if (p == 5) begin
					settings[4][0] = CfgW'($urandom_range(0, 200));
					settings[4][1] = CfgW'($urandom_range(1, 800));
					settings[4][2] = CfgW'($urandom_range(1, 600));
				end
				apply_setting(settings[p-1][0], settings[p-1][1], settings[p-1][2]);
			end
			// the last phase runs at full rate on both sides
			if (p == 6)
				idling = 1'b0;
			// every other phase crosses the 32-bit wrap
			if (p % 2 == 1)
				wall_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
			else
				wall_ms = $urandom();
			phase_end = requests + PhaseItems;
			while (requests < phase_end)
				gesture();
		end

		in_valid <= 1'b0;
		while (gestures.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests over %0d register settings", requests, settings_used);
		$display("results seen: %0d none, %0d short, %0d double, %0d long",
			gestures.seen[EV_NONE], gestures.seen[EV_SHORT],
			gestures.seen[EV_DOUBLE], gestures.seen[EV_LONG]);
		if (gestures.mismatches == 0)
			$display("button_gesture_classifier verification clean");
		else
			$display("button_gesture_classifier verification failed");
		$finish;
	end

endmodule

### files.f
sv/bgc_pkg.sv
sv/bgc_cfg.sv
sv/bgc_core.sv
sv/button_gesture_classifier.sv
dv/gesture_check_pkg.sv
dv/testbench.sv
